// ===== rtl/row_set_sequence_search_macros.svh =====
// Assertion macros used by the row set sequence search RTL
`ifndef ROW_SET_SEQUENCE_SEARCH_MACROS_SVH
`define ROW_SET_SEQUENCE_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RSSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsss: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RSSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsss: next-cycle check failed");

`endif

// ===== rtl/rsss_pkg.sv =====
// Package with widths, limits and register codes of the row set sequence search
`timescale 1ns / 1ps
package rsss_pkg;
  localparam int PATTERN_MAX    = 8;
  localparam int ROW_LENGTH_MAX = 4096;
  localparam int ROW_COUNT_MAX  = 65536;

  localparam int SYM_W  = 8;
  localparam int PAT_W  = 64;
  localparam int PLEN_W = 4;
  localparam int RLEN_W = 13;
  localparam int ROW_W  = 16;
  localparam int CNT_W  = $clog2(ROW_LENGTH_MAX + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_CHARS  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_ROW_LENGTH     = 2'd2
  } cfg_index_t;
endpackage

// ===== rtl/rsss_in_if.sv =====
// Input channel interface: one matrix character per beat
`timescale 1ns / 1ps
interface rsss_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsss_pkg::SYM_W-1:0] symbol;
  logic                      last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/rsss_out_if.sv =====
// Result channel interface: one search result per beat
`timescale 1ns / 1ps
interface rsss_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [rsss_pkg::ROW_W-1:0] start_row;

  modport source (output valid, output found, output start_row, input ready);
  modport sink   (input valid, input found, input start_row, output ready);
endinterface

// ===== rtl/rsss_cfg_if.sv =====
// Configuration write channel interface: register index and data per beat
`timescale 1ns / 1ps
interface rsss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rsss_pkg::CFG_IDX_W-1:0]  index;
  logic [rsss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/row_set_sequence_search.sv =====
// Top level of the row set sequence search: input stage, row matcher, result register
// Path: an accepted character beat is registered in the input stage; the result of
//   a last-marked beat is then registered in the result register and driven on out_ch.
// Throughput: one character per cycle; the input stage stalls only while it holds
//   a last beat and the result register is still full and not being taken.
// Reset: synchronous, active low; clears pipeline valids and the matcher state,
//   pattern registers go to zero and the row length to one.
`timescale 1ns / 1ps
`include "row_set_sequence_search_macros.svh"
module row_set_sequence_search (
  input logic        clk,
  input logic        rst_n,
  rsss_in_if.sink    in_ch,
  rsss_out_if.source out_ch,
  rsss_cfg_if.sink   cfg_ch
);
  import rsss_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROW_COUNT_MAX - 1);

  // Configuration registers
  logic [PAT_W-1:0]  pattern_chars_r;
  logic [PLEN_W-1:0] pattern_length_r;
  logic [RLEN_W-1:0] row_length_r;

  // Input stage
  logic             stg_valid_r, stg_valid_nxt;
  logic [SYM_W-1:0] stg_symbol_r;
  logic             stg_last_r;

  // Matcher state
  logic [PATTERN_MAX-1:0] row_hits_r, row_hits_nxt;
  logic [PATTERN_MAX-1:0] window_r, window_nxt;
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_count_r, row_count_nxt;
  logic                   match_seen_r, match_seen_nxt;
  logic [ROW_W-1:0]       match_row_r, match_row_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [ROW_W-1:0] out_start_row_r, out_start_row_nxt;

  // Datapath
  logic                   stg_adv;
  logic                   in_ready;
  logic [PLEN_W-1:0]      plen_eff;
  logic [CNT_W-1:0]       rowlen_eff;
  logic [PATTERN_MAX-1:0] plen_mask;
  logic [PATTERN_MAX-1:0] top_sel;
  logic [PATTERN_MAX-1:0] sym_hit;
  logic [PATTERN_MAX-1:0] hits_new;
  logic [PATTERN_MAX-1:0] win_new;
  logic [CNT_W-1:0]       col_inc;
  logic                   row_end;
  logic                   win_top;

  // The stage moves on unless it holds a last beat that has nowhere to go
  assign stg_adv  = stg_valid_r && (!stg_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !stg_valid_r || stg_adv;

  assign in_ch.ready      = in_ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.start_row = out_start_row_r;

  // Clamp the pattern length and the row length into their working ranges
  always_comb begin
    if (32'(pattern_length_r) > PATTERN_MAX) begin
      plen_eff = PLEN_W'(PATTERN_MAX);
    end else begin
      plen_eff = pattern_length_r;
    end
    if (row_length_r == '0) begin
      rowlen_eff = CNT_W'(1);
    end else if (32'(row_length_r) > ROW_LENGTH_MAX) begin
      rowlen_eff = CNT_W'(ROW_LENGTH_MAX);
    end else begin
      rowlen_eff = CNT_W'(row_length_r);
    end
  end

  // One comparator per pattern position, masked by the active length;
  // top_sel picks the window bit of the final pattern position.
  always_comb begin
    for (int a = 0; a < PATTERN_MAX; a++) begin
      plen_mask[a] = a < int'(plen_eff);
      top_sel[a]   = (a + 1) == int'(plen_eff);
      sym_hit[a]   = plen_mask[a] &&
                     (pattern_chars_r[SYM_W*a +: SYM_W] == stg_symbol_r);
    end
  end

  assign hits_new = row_hits_r | sym_hit;
  // Shift-and over rows: extend every surviving run by this row
  assign win_new  = PATTERN_MAX'({window_r, 1'b1}) & hits_new & plen_mask;
  assign win_top  = |(win_new & top_sel);
  assign col_inc  = col_r + CNT_W'(1);
  // A last beat closes the row even when it is partial
  assign row_end  = (col_inc >= rowlen_eff) || stg_last_r;

  always_comb begin
    stg_valid_nxt     = stg_valid_r;
    row_hits_nxt      = row_hits_r;
    window_nxt        = window_r;
    col_nxt           = col_r;
    row_count_nxt     = row_count_r;
    match_seen_nxt    = match_seen_r;
    match_row_nxt     = match_row_r;
    out_valid_nxt     = out_valid_r;
    out_found_nxt     = out_found_r;
    out_start_row_nxt = out_start_row_r;

    if (in_ready) begin
      stg_valid_nxt = in_ch.valid;
    end

    // Drop the result once the sink takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (stg_adv) begin
      row_hits_nxt = hits_new;
      col_nxt      = col_inc;
      if (row_end) begin
        // Rows past the saturation point are not evaluated
        if (row_count_r < ROW_LIMIT) begin
          if (plen_eff != '0) begin
            window_nxt = win_new;
            if (!match_seen_r && win_top) begin
              match_seen_nxt = 1'b1;
              match_row_nxt  = row_count_r - ROW_W'(plen_eff) + ROW_W'(1);
            end
          end else begin
            window_nxt = '0;
          end
          row_count_nxt = row_count_r + ROW_W'(1);
        end
        row_hits_nxt = '0;
        col_nxt      = '0;
      end

      if (stg_last_r) begin
        out_valid_nxt = 1'b1;
        if (plen_eff == '0) begin
          // Empty pattern matches at the first row
          out_found_nxt     = 1'b1;
          out_start_row_nxt = '0;
        end else begin
          out_found_nxt     = match_seen_nxt;
          out_start_row_nxt = match_seen_nxt ? match_row_nxt : '0;
        end
        // Clear for the next matrix
        row_hits_nxt   = '0;
        window_nxt     = '0;
        col_nxt        = '0;
        row_count_nxt  = '0;
        match_seen_nxt = 1'b0;
        match_row_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_chars_r  <= '0;
      pattern_length_r <= '0;
      row_length_r     <= RLEN_W'(1);
      stg_valid_r      <= 1'b0;
      row_hits_r       <= '0;
      window_r         <= '0;
      col_r            <= '0;
      row_count_r      <= '0;
      match_seen_r     <= 1'b0;
      match_row_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_index_t'(cfg_ch.index))
          CFG_PATTERN_CHARS: begin
            pattern_chars_r <= cfg_ch.data[PAT_W-1:0];
          end
          CFG_PATTERN_LENGTH: begin
            pattern_length_r <= cfg_ch.data[PLEN_W-1:0];
          end
          CFG_ROW_LENGTH: begin
            row_length_r <= cfg_ch.data[RLEN_W-1:0];
          end
          default: begin
            // Unknown register index: ignore the write
          end
        endcase
      end
      stg_valid_r  <= stg_valid_nxt;
      row_hits_r   <= row_hits_nxt;
      window_r     <= window_nxt;
      col_r        <= col_nxt;
      row_count_r  <= row_count_nxt;
      match_seen_r <= match_seen_nxt;
      match_row_r  <= match_row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      stg_symbol_r <= in_ch.symbol;
      stg_last_r   <= in_ch.last;
    end
    out_found_r     <= out_found_nxt;
    out_start_row_r <= out_start_row_nxt;
  end

  `RSSS_ASSERT_NOW(a_stall_only_on_full_result, clk, rst_n,
    !in_ready, stg_valid_r && stg_last_r && out_valid_r && !out_ch.ready)
  `RSSS_ASSERT_NEXT(a_last_loads_result, clk, rst_n,
    stg_adv && stg_last_r, out_valid_r)
  `RSSS_ASSERT_NEXT(a_last_clears_state, clk, rst_n,
    stg_adv && stg_last_r, row_count_r == '0 && col_r == '0 && !match_seen_r)
  `RSSS_ASSERT_NOW(a_miss_reports_row_zero, clk, rst_n,
    out_valid_r && !out_found_r, out_start_row_r == '0)

endmodule

// ===== test/tb_row_set_sequence_search.sv =====
// Self-checking testbench for the row set sequence search block
`timescale 1ns / 1ps
module tb_row_set_sequence_search;
  import rsss_pkg::*;

  // One matrix character as it travels on the input channel
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } char_beat_t;

  // One search outcome as it travels on the result channel
  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] start_row;
  } search_result_t;

  // Receiver hold-off length, long enough for several matrices to pile up
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  rsss_in_if  in_if ();
  rsss_out_if out_if ();
  rsss_cfg_if cfg_if ();

  row_set_sequence_search i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Characters waiting to be sent; the head is the one on the bus
  char_beat_t     symbol_queue[$];
  // Search outcomes predicted but not yet seen on the result channel
  search_result_t result_due[$];

  // Shadow copy of the register file, updated on each configuration beat
  logic [PAT_W-1:0]  pat_chars_cfg;
  logic [PLEN_W-1:0] pat_len_cfg;
  logic [RLEN_W-1:0] row_len_cfg;

  // Search state mirrored from the block's behavior
  logic [7:0]       hit_mask;
  logic [7:0]       window;
  int               col_count;
  int               rows_done;
  logic             match_seen;
  logic [ROW_W-1:0] match_row;

  int errors;
  int random_items;

  // Sender pacing
  int burst_left;
  int gap_left;

  // Receiver pacing
  logic [7:0]     stall_pattern;
  int             pattern_age;
  int             hold_left;
  int             holds_done;
  int             results_taken;
  search_result_t want;

  // Clock: 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, well after the slowest legal run: about 3k characters, sent in bursts
  // with gaps, plus receiver stalls and two hold-offs.
  initial begin
    #800_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int eff_pattern_length();
    return (pat_len_cfg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_cfg);
  endfunction

  function automatic int eff_row_length();
    if (row_len_cfg == '0) return 1;
    return (row_len_cfg > ROW_LENGTH_MAX) ? ROW_LENGTH_MAX : int'(row_len_cfg);
  endfunction

  // Advance the search by one accepted character; queue the outcome on a last beat
  function automatic void track_symbol(logic [SYM_W-1:0] sym, logic is_last);
    int             plen;
    int             a;
    int             mask;
    search_result_t res;
    plen = eff_pattern_length();
    for (a = 0; a < plen; a++) begin
      if (pat_chars_cfg[8*a +: 8] == sym) hit_mask[a] = 1'b1;
    end
    col_count++;
    // Close the row when it is full, or early on the last character
    if (col_count >= eff_row_length() || is_last) begin
      // Once the row counter saturates, further rows are not evaluated
      if (rows_done < ROW_COUNT_MAX - 1) begin
        if (plen > 0) begin
          mask   = (1 << plen) - 1;
          window = ((window << 1) | 8'd1) & hit_mask & mask[7:0];
          if (!match_seen && window[plen-1]) begin
            match_seen = 1'b1;
            match_row  = ROW_W'(rows_done - (plen - 1));
          end
        end else begin
          window = '0;
        end
        rows_done++;
      end
      hit_mask  = '0;
      col_count = 0;
    end
    if (is_last) begin
      // An empty pattern matches at row zero, even for a one-character matrix
      res.found     = (plen == 0) || match_seen;
      res.start_row = (plen != 0 && match_seen) ? match_row : '0;
      result_due.push_back(res);
      hit_mask   = '0;
      window     = '0;
      col_count  = 0;
      rows_done  = 0;
      match_seen = 1'b0;
      match_row  = '0;
    end
  endfunction

  // Driver: present the head of the queue, in bursts with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        track_symbol(in_if.symbol, in_if.last);
        void'(symbol_queue.pop_front());
      end
      // Hold the current beat until taken; only then pick the next one
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (symbol_queue.size() > 0) begin
          in_if.valid  <= 1'b1;
          in_if.symbol <= symbol_queue[0].symbol;
          in_if.last   <= symbol_queue[0].last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            // A quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver: check each result beat, then set ready for the next edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_pattern = 8'hFF;
      pattern_age   = 0;
      hold_left     = 0;
      holds_done    = 0;
      results_taken = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_due.size() == 0) begin
          $error("result with nothing due: found=%0b start_row=%0d",
                 out_if.found, out_if.start_row);
          errors++;
        end else begin
          want = result_due.pop_front();
          if (out_if.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_if.found);
            errors++;
          end
          if (out_if.start_row !== want.start_row) begin
            $error("start_row: expected %0d, got %0d", want.start_row, out_if.start_row);
            errors++;
          end
          results_taken++;
          // Up to twice in the run, drop ready for a long stretch while plenty of
          // characters are still queued, so the block backs up
          if (results_taken >= 25 && holds_done < 2 && symbol_queue.size() >= 32) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= stall_pattern[0];
      end
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      pattern_age++;
      if (pattern_age == 37) begin
        pattern_age   = 0;
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      end
    end
  end

  task automatic push_beat(input logic [SYM_W-1:0] sym, input logic is_last);
    char_beat_t beat;
    beat.symbol = sym;
    beat.last   = is_last;
    symbol_queue.push_back(beat);
  endtask

  // Write one register; update the shadow copy on the accepting edge
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_PATTERN_CHARS:  pat_chars_cfg = value;
      CFG_PATTERN_LENGTH: pat_len_cfg   = value[PLEN_W-1:0];
      CFG_ROW_LENGTH:     row_len_cfg   = value[RLEN_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every character is sent and every outcome checked, then let
  // the pipeline drain before touching the registers
  task automatic wait_idle();
    while (symbol_queue.size() != 0 || result_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Queue one matrix of random rows; often plant the pattern down a run of rows
  task automatic queue_random_matrix();
    int         rlen;
    int         plen;
    int         nrows;
    int         tail;
    int         total;
    int         start;
    int         row;
    int         col;
    int         a;
    int         pick;
    logic [7:0] cells[];
    rlen = eff_row_length();
    plen = eff_pattern_length();
    // Long rows: keep to a single partial row so the run stays short
    if (rlen > 16) begin
      nrows = 1;
      tail  = $urandom_range(1, 24);
    end else begin
      nrows = $urandom_range(1, 10);
      tail  = $urandom_range(1, rlen);
    end
    total = (nrows - 1) * rlen + tail;
    cells = new[total];
    foreach (cells[i]) begin
      pick = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 6) cells[i] = pat_chars_cfg[8*pick +: 8];
      else                          cells[i] = 8'($urandom_range(0, 255));
    end
    if (plen > 0 && nrows >= plen && $urandom_range(0, 1) == 1) begin
      start = $urandom_range(0, nrows - plen);
      for (a = 0; a < plen; a++) begin
        row = start + a;
        col = $urandom_range(0, ((row == nrows - 1) ? tail : rlen) - 1);
        cells[row*rlen + col] = pat_chars_cfg[8*a +: 8];
      end
    end
    foreach (cells[i]) push_beat(cells[i], i == total - 1);
    random_items += total;
  endtask

  initial begin
    int         n;
    int         plen_pick;
    int         rlen_pick;
    logic [63:0] chars;
    errors        = 0;
    random_items  = 0;
    pat_chars_cfg = '0;
    pat_len_cfg   = '0;
    row_len_cfg   = RLEN_W'(1);
    hit_mask      = '0;
    window        = '0;
    col_count     = 0;
    rows_done     = 0;
    match_seen    = 1'b0;
    match_row     = '0;
    in_if.valid   = 1'b0;
    in_if.symbol  = '0;
    in_if.last    = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_PATTERN_CHARS;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty pattern, so a lone last character still matches
    push_beat(8'h00, 1'b1);
    wait_idle();

    // Extreme characters; an oversized length clamps to eight, row length zero acts as one
    write_reg(CFG_PATTERN_CHARS, 64'h0706_0504_0302_FF00);
    write_reg(CFG_PATTERN_LENGTH, 64'd15);
    write_reg(CFG_ROW_LENGTH, 64'd0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    for (n = 2; n < 8; n++) push_beat(8'(n), n == 7);
    push_beat(8'h07, 1'b0);
    push_beat(8'h00, 1'b1);
    wait_idle();

    // Full-length pattern starting at row one
    write_reg(CFG_PATTERN_LENGTH, 64'd8);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    for (n = 2; n < 8; n++) push_beat(8'(n), n == 7);
    wait_idle();

    // Partial final row: the last character closes a one-character row
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    write_reg(CFG_ROW_LENGTH, 64'd3);
    push_beat(8'h11, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h22, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // Random phases: fresh settings each time, then a run of small matrices
    while (random_items < 1700) begin
      case ($urandom_range(0, 3))
        0:       chars = 64'hFFFF_FFFF_FFFF_FFFF;
        1:       chars = {$urandom, $urandom};
        2:       chars = '0;
        default: begin
          for (n = 0; n < 8; n++) chars[8*n +: 8] = 8'h61 + 8'($urandom_range(0, 3));
        end
      endcase
      plen_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0:       rlen_pick = 0;
        1:       rlen_pick = ROW_LENGTH_MAX;
        2:       rlen_pick = 8191;
        default: rlen_pick = $urandom_range(1, 8);
      endcase
      write_reg(CFG_PATTERN_CHARS, chars);
      write_reg(CFG_PATTERN_LENGTH, 64'(plen_pick));
      write_reg(CFG_ROW_LENGTH, 64'(rlen_pick));
      repeat ($urandom_range(6, 16)) queue_random_matrix();
      wait_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== row_set_sequence_search.f =====
+incdir+rtl
rtl/rsss_pkg.sv
rtl/rsss_in_if.sv
rtl/rsss_out_if.sv
rtl/rsss_cfg_if.sv
rtl/row_set_sequence_search.sv
test/tb_row_set_sequence_search.sv
